@@ sv/cpts_pkg.sv @@
package cpts_pkg;

    localparam int SEQ_W      = 16;
    localparam int SHOT_W     = 21;
    localparam int TICK_W     = 32;
    localparam int RATE_W     = 16;
    localparam int WIN_W      = 10;
    localparam int PULSE_W    = 4;
    localparam int BUZ_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 128;

    localparam logic [SEQ_W-1:0]  AUX_ON_COUNT  = 16'd1;
    localparam logic [SEQ_W-1:0]  AUX_OFF_COUNT = 16'd6;
    localparam logic [SEQ_W-1:0]  MAIN_ON_COUNT = 16'd23;
    localparam logic [WIN_W-1:0]  WINDOW_LAST   = 10'd1000;
    localparam logic [SHOT_W-1:0] LIFETIME_MAX  = 21'd2000000;
    localparam logic [RATE_W-1:0] RATE_MAX      = 16'hffff;

    localparam logic [SEQ_W-1:0]  MAIN_ON_TIME_RST = 16'd10;
    localparam logic [SEQ_W-1:0]  CYCLE_LEN_RST    = 16'd1000;
    localparam logic [SHOT_W-1:0] SHOT_LIMIT_RST   = 21'd2000000;

    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_ON_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOT_LIMIT   = 2'd2;

    typedef struct packed {
        logic              aux_coil;
        logic              main_coil;
        logic [SHOT_W-1:0] shot_count;
        logic [SHOT_W-1:0] lifetime_shots;
        logic [TICK_W-1:0] work_ticks;
    } t_coil_stat;

endpackage

@@ sv/cpts_coil.sv @@
module cpts_coil
    import cpts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_work_enable,
    input  logic [SEQ_W-1:0]  i_main_on_time,
    input  logic [SEQ_W-1:0]  i_cycle_length,
    input  logic [SHOT_W-1:0] i_shot_limit,
    output t_coil_stat        o_next
);

    logic [SEQ_W-1:0]  r_seq_cnt, n_seq_cnt;
    logic              r_aux, n_aux;
    logic              r_main, n_main;
    logic [TICK_W-1:0] r_work_ticks, n_work_ticks;
    logic [SHOT_W-1:0] r_shots, n_shots;
    logic [SHOT_W-1:0] r_total, n_total;
    logic [SEQ_W-1:0]  cnt_inc;
    logic [SEQ_W:0]    main_off_cnt;

    assign cnt_inc      = r_seq_cnt + 16'd1;
    assign main_off_cnt = {1'b0, i_main_on_time} + {1'b0, MAIN_ON_COUNT};

    always_comb begin
        n_seq_cnt    = r_seq_cnt;
        n_aux        = r_aux;
        n_main       = r_main;
        n_work_ticks = r_work_ticks;
        n_shots      = r_shots;
        n_total      = r_total;
        if (i_work_enable) begin
            n_work_ticks = r_work_ticks + 32'd1;
            n_seq_cnt    = cnt_inc;
            if (cnt_inc == AUX_ON_COUNT) begin
                n_aux = 1'b1;
            end else if (cnt_inc == AUX_OFF_COUNT) begin
                n_aux = 1'b0;
            end else if (cnt_inc == MAIN_ON_COUNT) begin
                n_main = 1'b1;
            end else if ({1'b0, cnt_inc} == main_off_cnt) begin
                n_main = 1'b0;
                if (r_shots < i_shot_limit) begin
                    n_shots = r_shots + 21'd1;
                end
                if (r_total < LIFETIME_MAX) begin
                    n_total = r_total + 21'd1;
                end
            end else if (cnt_inc >= i_cycle_length) begin
                n_seq_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_cnt    <= '0;
            r_aux        <= 1'b0;
            r_main       <= 1'b0;
            r_work_ticks <= '0;
            r_shots      <= '0;
            r_total      <= '0;
        end else if (i_step) begin
            r_seq_cnt    <= n_seq_cnt;
            r_aux        <= n_aux;
            r_main       <= n_main;
            r_work_ticks <= n_work_ticks;
            r_shots      <= n_shots;
            r_total      <= n_total;
        end
    end

    always_comb begin
        o_next.aux_coil       = n_aux;
        o_next.main_coil      = n_main;
        o_next.shot_count     = n_shots;
        o_next.lifetime_shots = n_total;
        o_next.work_ticks     = n_work_ticks;
    end

`ifndef SYNTHESIS
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_seq_cnt) && $stable(r_work_ticks) && $stable(r_shots))
        else $error("coil state changed without a step");

    a_total_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= LIFETIME_MAX)
        else $error("lifetime shots above limit");

    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_total >= $past(r_total) && r_shots >= $past(r_shots))
        else $error("shot counter decreased");

    a_main_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_main) |-> r_seq_cnt == MAIN_ON_COUNT)
        else $error("main coil switched on off its count");

    a_shot_with_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_work_enable |=> $stable(r_aux) && $stable(r_main))
        else $error("coil level changed while work disabled");
`endif

endmodule

@@ sv/coil_pulse_tick_sequencer_top.sv @@
// Coil pulse tick sequencer.
// Input stream: one transaction per 1 ms tick, carrying the work enable,
// the flow pulse count and an optional buzzer load. Each tick gives exactly
// one output transaction with the coil and buzzer levels, the latched flow
// rate, the shot counters and the work and system tick counters, all taken
// after the tick is applied.
// Config channel: index 0 main_on_time, 1 cycle_length, 2 shot_limit; writes
// are always taken and only expected while the stream is idle.
// Pipeline: an accepted tick is held in the input register and is
// applied as it moves into the output register, which drives its result
// onto the output. Throughput: one tick per cycle while the receiver does
// not stall, set by the single input and output register pair; all counter
// updates are combinational between the two registers.
// When the receiver stalls the output register holds, the input register
// fills, and s_axis_tready drops until the output transaction completes.
// Reset (synchronous, active low) clears all counters and levels, empties
// both registers and restores the config defaults.
module coil_pulse_tick_sequencer_top
    import cpts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [0] work_enable, [4:1] flow_pulses, [20:5] buzzer_load, [23:21] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] aux_coil, [1] main_coil, [2] buzzer, [18:3] flow_rate,
    // [39:19] shot_count, [60:40] lifetime_shots, [92:61] work_ticks,
    // [124:93] tick_count, [127:125] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SEQ_W-1:0]      r_main_on_time;
    logic [SEQ_W-1:0]      r_cycle_length;
    logic [SHOT_W-1:0]     r_shot_limit;

    logic                  r_in_valid;
    logic                  r_in_enable;
    logic [PULSE_W-1:0]    r_in_pulses;
    logic [BUZ_W-1:0]      r_in_load;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [TICK_W-1:0]     r_sys_ticks, n_sys_ticks;
    logic [BUZ_W-1:0]      r_buz_rem, n_buz_rem;
    logic                  r_buz_lvl, n_buz_lvl;
    logic [WIN_W-1:0]      r_win_ticks, n_win_ticks;
    logic [RATE_W-1:0]     r_win_pulses, n_win_pulses;
    logic [RATE_W-1:0]     r_rate, n_rate;

    logic                  advance;
    logic [BUZ_W-1:0]      buz_loaded;
    logic [RATE_W:0]       pulse_sum;
    logic [RATE_W-1:0]     pulse_sat;
    t_coil_stat            coil_next;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_on_time <= MAIN_ON_TIME_RST;
            r_cycle_length <= CYCLE_LEN_RST;
            r_shot_limit   <= SHOT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAIN_ON_TIME: r_main_on_time <= i_cfg_data[SEQ_W-1:0];
                CFG_CYCLE_LENGTH: r_cycle_length <= i_cfg_data[SEQ_W-1:0];
                CFG_SHOT_LIMIT:   r_shot_limit   <= i_cfg_data[SHOT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_enable <= i_s_axis_tdata[0];
            r_in_pulses <= i_s_axis_tdata[4:1];
            r_in_load   <= i_s_axis_tdata[20:5];
        end
    end

    always_comb begin
        n_sys_ticks = r_sys_ticks + 32'd1;

        buz_loaded = (r_in_load != '0) ? r_in_load : r_buz_rem;
        n_buz_lvl  = (r_in_load != '0) ? 1'b1 : r_buz_lvl;
        n_buz_rem  = buz_loaded;
        if (buz_loaded != '0) begin
            n_buz_rem = buz_loaded - 16'd1;
            if (n_buz_rem == '0) begin
                n_buz_lvl = 1'b0;
            end
        end

        pulse_sum = {1'b0, r_win_pulses} + {{(RATE_W+1-PULSE_W){1'b0}}, r_in_pulses};
        pulse_sat = pulse_sum[RATE_W] ? RATE_MAX : pulse_sum[RATE_W-1:0];
        if (r_win_ticks >= WINDOW_LAST) begin
            n_win_ticks  = '0;
            n_rate       = pulse_sat;
            n_win_pulses = '0;
        end else begin
            n_win_ticks  = r_win_ticks + 10'd1;
            n_rate       = r_rate;
            n_win_pulses = pulse_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_ticks  <= '0;
            r_buz_rem    <= '0;
            r_buz_lvl    <= 1'b0;
            r_win_ticks  <= '0;
            r_win_pulses <= '0;
            r_rate       <= '0;
        end else if (advance) begin
            r_sys_ticks  <= n_sys_ticks;
            r_buz_rem    <= n_buz_rem;
            r_buz_lvl    <= n_buz_lvl;
            r_win_ticks  <= n_win_ticks;
            r_win_pulses <= n_win_pulses;
            r_rate       <= n_rate;
        end
    end

    cpts_coil u_coil (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_work_enable  (r_in_enable),
        .i_main_on_time (r_main_on_time),
        .i_cycle_length (r_cycle_length),
        .i_shot_limit   (r_shot_limit),
        .o_next         (coil_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {3'b000, n_sys_ticks, coil_next.work_ticks,
                           coil_next.lifetime_shots, coil_next.shot_count,
                           n_rate, n_buz_lvl, coil_next.main_coil,
                           coil_next.aux_coil};
        end
    end

endmodule
